// File: rtl/fwm_pkg.sv
// Shared types, opcodes and constants for the frame word mix unit.
// No dependencies; used by every module in rtl.
package fwm_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic                 exit_request;
      logic [7:0]           exit_code;
      logic [7:0][31:0]     words;
   } frame_type;

   typedef struct packed {
      logic      mix_tail;
      frame_type frame;
   } mid_type;

   localparam word_type OP_EXIT  = 32'd0;
   localparam word_type OP_MIX   = 32'd2;
   localparam word_type OP_KEY   = 32'd3;
   localparam word_type OP_ROT   = 32'd4;
   localparam word_type OP_FOLD  = 32'd5;
   localparam word_type OP_MAJ   = 32'd6;
   localparam word_type OP_DESC  = 32'd7;

   localparam word_type MIX_K0    = 32'h9e3779b9;
   localparam word_type MIX_K1    = 32'h7f4a7c15;
   localparam word_type KEY_MASK  = 32'ha5a5a5a5;
   localparam word_type DESC_W1   = 32'h52414643;
   localparam word_type DESC_W2   = 32'h4f4445a6;
   localparam word_type DESC_W3   = 32'd2;
   localparam word_type DESC_W4   = 32'd32;
   localparam word_type DESC_W5   = 32'd7;
   localparam word_type ALL_ONES  = 32'hffffffff;
   localparam word_type STATUS_OK = 32'd0;

   function automatic word_type ror32(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: rtl/fwm_xform.sv
// First stage of the frame transform: decodes the opcode, finishes every
// operation but the tail of the mix chain. Depends on fwm_pkg.
module fwm_xform
   import fwm_pkg::*;
(
   input  logic [7:0][31:0] frame_words,
   output mid_type          mid
);

   always_comb begin
      word_type a;
      word_type b;
      word_type c;
      word_type k;
      a = '0;
      b = '0;
      c = '0;
      k = '0;
      mid = '0;
      mid.frame.words = frame_words;
      case (frame_words[0])
         OP_EXIT: begin
            mid.frame.exit_request = 1'b1;
            mid.frame.exit_code    = frame_words[1][7:0];
            mid.frame.words        = '0;
         end
         OP_MIX: begin
            a = frame_words[1] + ror32(frame_words[2] ^ MIX_K0, 5);
            b = frame_words[2] ^ ror32(frame_words[3] + MIX_K1, 7);
            mid.mix_tail = 1'b1;
            mid.frame.words[0] = STATUS_OK;
            mid.frame.words[1] = a;
            mid.frame.words[2] = b;
            mid.frame.words[3] = frame_words[3] + ror32(frame_words[4] ^ a, 11);
            mid.frame.words[4] = frame_words[4] ^ ror32(frame_words[5] + b, 13);
         end
         OP_KEY: begin
            k = frame_words[1] ^ KEY_MASK;
            mid.frame.words[0] = STATUS_OK;
            mid.frame.words[2] = frame_words[2] ^ k;
            mid.frame.words[3] = frame_words[3] ^ ror32(k, 3);
            mid.frame.words[4] = frame_words[4] ^ ror32(k, 7);
            mid.frame.words[5] = frame_words[5] ^ ror32(k, 11);
            mid.frame.words[6] = frame_words[6] ^ ror32(k, 17);
            mid.frame.words[7] = frame_words[7] ^ ror32(k, 23);
         end
         OP_ROT: begin
            mid.frame.words[0] = STATUS_OK;
            mid.frame.words[1] = ror32(frame_words[1], 1);
            mid.frame.words[2] = ror32(frame_words[2], 3);
            mid.frame.words[3] = ror32(frame_words[3], 5);
            mid.frame.words[4] = ror32(frame_words[4], 7);
            mid.frame.words[5] = ror32(frame_words[5], 11);
            mid.frame.words[6] = ror32(frame_words[6], 13);
            mid.frame.words[7] = ror32(frame_words[7], 17);
         end
         OP_FOLD: begin
            mid.frame.words[0] = STATUS_OK;
            mid.frame.words[1] = frame_words[1] ^ frame_words[2] ^ frame_words[3]
                               ^ frame_words[4] ^ frame_words[5] ^ frame_words[6]
                               ^ frame_words[7];
         end
         OP_MAJ: begin
            a = frame_words[1];
            b = frame_words[2];
            c = frame_words[3];
            mid.frame.words[0] = {31'd0, ((a | b | c) == '0)};
            mid.frame.words[1] = (a ^ b) + c;
            mid.frame.words[2] = (a & b) | (b & c) | (c & a);
         end
         OP_DESC: begin
            mid.frame.words[0] = STATUS_OK;
            mid.frame.words[1] = DESC_W1;
            mid.frame.words[2] = DESC_W2;
            mid.frame.words[3] = DESC_W3;
            mid.frame.words[4] = DESC_W4;
            mid.frame.words[5] = DESC_W5;
            mid.frame.words[6] = '0;
            mid.frame.words[7] = '0;
         end
         default: begin
            mid.frame.words[0] = ALL_ONES;
         end
      endcase
   end

endmodule

// File: rtl/fwm_mix_tail.sv
// Second stage of the frame transform: finishes words 5 to 7 of the mix
// chain and passes every other frame through. Depends on fwm_pkg.
module fwm_mix_tail
   import fwm_pkg::*;
(
   input  mid_type   mid,
   output frame_type frame
);

   always_comb begin
      word_type e;
      e = mid.frame.words[5] + ror32(mid.frame.words[6] ^ mid.frame.words[3], 17);
      frame = mid.frame;
      if (mid.mix_tail) begin
         frame.words[5] = e;
         frame.words[6] = mid.frame.words[6]
                        ^ ror32(mid.frame.words[7] + mid.frame.words[4], 19);
         frame.words[7] = mid.frame.words[7] + ror32(mid.frame.words[1] ^ e, 23);
      end
   end

endmodule

// File: rtl/frame_word_mix_unit.sv
// Top level of the frame word mix unit: input, middle and result registers.
// Depends on fwm_pkg, fwm_xform and fwm_mix_tail.
//
// One frame is taken on every clock edge where start is high; busy is always
// low. Each frame gives exactly one result, shown for one cycle with
// rsp_strobe, in order. Each frame passes through the input register, the
// register that splits the mix chain, and the result register, in that order.
// The receiver cannot stall, so a result is never held.
module frame_word_mix_unit
   import fwm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_opcode,
   input  logic [31:0] req_word1,
   input  logic [31:0] req_word2,
   input  logic [31:0] req_word3,
   input  logic [31:0] req_word4,
   input  logic [31:0] req_word5,
   input  logic [31:0] req_word6,
   input  logic [31:0] req_word7,
   output logic        rsp_strobe,
   output logic        rsp_exit_request,
   output logic [7:0]  rsp_exit_code,
   output logic [31:0] rsp_status_word,
   output logic [31:0] rsp_out_word1,
   output logic [31:0] rsp_out_word2,
   output logic [31:0] rsp_out_word3,
   output logic [31:0] rsp_out_word4,
   output logic [31:0] rsp_out_word5,
   output logic [31:0] rsp_out_word6,
   output logic [31:0] rsp_out_word7
);

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0][31:0] in_words_ff;
   logic [7:0][31:0] in_words_in;
   logic             mid_valid_ff;
   mid_type          mid_ff;
   mid_type          mid_in;
   logic             rsp_valid_ff;
   frame_type        rsp_ff;
   frame_type        rsp_in;

   assign busy        = 1'b0;
   assign in_valid_in = start & ~busy;

   always_comb begin
      in_words_in[0] = req_opcode;
      in_words_in[1] = req_word1;
      in_words_in[2] = req_word2;
      in_words_in[3] = req_word3;
      in_words_in[4] = req_word4;
      in_words_in[5] = req_word5;
      in_words_in[6] = req_word6;
      in_words_in[7] = req_word7;
   end

   fwm_xform u_xform (
      .frame_words (in_words_ff),
      .mid         (mid_in)
   );

   fwm_mix_tail u_mix_tail (
      .mid   (mid_ff),
      .frame (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= in_valid_ff;
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_words_ff <= in_words_in;
      mid_ff      <= mid_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_exit_request = rsp_ff.exit_request;
   assign rsp_exit_code    = rsp_ff.exit_code;
   assign rsp_status_word  = rsp_ff.words[0];
   assign rsp_out_word1    = rsp_ff.words[1];
   assign rsp_out_word2    = rsp_ff.words[2];
   assign rsp_out_word3    = rsp_ff.words[3];
   assign rsp_out_word4    = rsp_ff.words[4];
   assign rsp_out_word5    = rsp_ff.words[5];
   assign rsp_out_word6    = rsp_ff.words[6];
   assign rsp_out_word7    = rsp_ff.words[7];

   a_strobe_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 3))
      else $error("result strobe without a matching transfer");

   a_exit_clears_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_exit_request) |->
         (rsp_status_word == STATUS_OK && rsp_out_word1 == '0 && rsp_out_word7 == '0))
      else $error("exit result carries frame words");

   a_code_only_on_exit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_exit_request) |-> (rsp_exit_code == '0))
      else $error("exit code set without exit request");

   a_exit_opcode_gives_exit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_opcode, 3) == OP_EXIT) |-> rsp_exit_request)
      else $error("exit opcode did not raise exit request");

endmodule

// File: test/tb_frame_word_mix_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for frame_word_mix_unit: a directed table of frames, then random frames
// in bursts, each result checked word by word against its table entry or a local predictor.
// Depends on fwm_pkg and the frame_word_mix_unit RTL.
module tb_frame_word_mix_unit
   import fwm_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_ITEMS = 1550;
   localparam int unsigned REPORT_MAX   = 10;
   localparam int unsigned TAIL_CYCLES  = 8;

   typedef logic [7:0][31:0] req_frame_type;

   typedef struct {
      req_frame_type frame;
      bit            typed;
      frame_type     result;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_opcode = '0;
   logic [31:0] req_word1 = '0;
   logic [31:0] req_word2 = '0;
   logic [31:0] req_word3 = '0;
   logic [31:0] req_word4 = '0;
   logic [31:0] req_word5 = '0;
   logic [31:0] req_word6 = '0;
   logic [31:0] req_word7 = '0;
   logic        rsp_strobe;
   logic        rsp_exit_request;
   logic [7:0]  rsp_exit_code;
   logic [31:0] rsp_status_word;
   logic [31:0] rsp_out_word1;
   logic [31:0] rsp_out_word2;
   logic [31:0] rsp_out_word3;
   logic [31:0] rsp_out_word4;
   logic [31:0] rsp_out_word5;
   logic [31:0] rsp_out_word6;
   logic [31:0] rsp_out_word7;

   stim_row_type stim_q[$];
   frame_type    pending_frames[$];
   frame_type    held_expect = '0;
   int unsigned  err_count = 0;
   int unsigned  result_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  exit_count = 0;
   int unsigned  unknown_count = 0;
   int unsigned  xform_count = 0;

   frame_word_mix_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_word1(req_word1),
      .req_word2(req_word2),
      .req_word3(req_word3),
      .req_word4(req_word4),
      .req_word5(req_word5),
      .req_word6(req_word6),
      .req_word7(req_word7),
      .rsp_strobe(rsp_strobe),
      .rsp_exit_request(rsp_exit_request),
      .rsp_exit_code(rsp_exit_code),
      .rsp_status_word(rsp_status_word),
      .rsp_out_word1(rsp_out_word1),
      .rsp_out_word2(rsp_out_word2),
      .rsp_out_word3(rsp_out_word3),
      .rsp_out_word4(rsp_out_word4),
      .rsp_out_word5(rsp_out_word5),
      .rsp_out_word6(rsp_out_word6),
      .rsp_out_word7(rsp_out_word7)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic word_type rot_right(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic req_frame_type frm(input word_type op, input word_type a,
                                         input word_type b, input word_type c,
                                         input word_type d, input word_type e,
                                         input word_type f, input word_type g);
      return {g, f, e, d, c, b, a, op};
   endfunction

   function automatic frame_type transform_frame(input req_frame_type f);
      frame_type r;
      word_type  a, b, c, d, e, g, h, k;
      r = '0;
      r.words = f;
      a = f[1]; b = f[2]; c = f[3]; d = f[4]; e = f[5]; g = f[6]; h = f[7];
      case (f[0])
         OP_EXIT: begin
            r.words = '0;
            r.exit_request = 1'b1;
            r.exit_code = a[7:0];
         end
         OP_MIX: begin
            a = a + rot_right(b ^ MIX_K0, 5);
            b = b ^ rot_right(c + MIX_K1, 7);
            c = c + rot_right(d ^ a, 11);
            d = d ^ rot_right(e + b, 13);
            e = e + rot_right(g ^ c, 17);
            g = g ^ rot_right(h + d, 19);
            h = h + rot_right(a ^ e, 23);
            r.words = {h, g, e, d, c, b, a, STATUS_OK};
         end
         OP_KEY: begin
            k = a ^ KEY_MASK;
            r.words = {h ^ rot_right(k, 23), g ^ rot_right(k, 17), e ^ rot_right(k, 11),
                       d ^ rot_right(k, 7), c ^ rot_right(k, 3), b ^ k, a, STATUS_OK};
         end
         OP_ROT: begin
            r.words = {rot_right(h, 17), rot_right(g, 13), rot_right(e, 11), rot_right(d, 7),
                       rot_right(c, 5), rot_right(b, 3), rot_right(a, 1), STATUS_OK};
         end
         OP_FOLD: begin
            r.words[1] = a ^ b ^ c ^ d ^ e ^ g ^ h;
            r.words[0] = STATUS_OK;
         end
         OP_MAJ: begin
            r.words[0] = ((a | b | c) == '0) ? 32'd1 : STATUS_OK;
            r.words[1] = (a ^ b) + c;
            r.words[2] = (a & b) | (b & c) | (c & a);
         end
         OP_DESC: begin
            r.words = {32'd0, 32'd0, DESC_W5, DESC_W4, DESC_W3, DESC_W2, DESC_W1, STATUS_OK};
         end
         default: r.words[0] = ALL_ONES;
      endcase
      return r;
   endfunction

   function automatic void add_row(input req_frame_type f, input bit typed,
                                   input frame_type result);
      stim_row_type row;
      row.frame = f;
      row.typed = typed;
      row.result = result;
      stim_q.push_back(row);
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALL_ONES;
         2: return 32'd1 << $urandom_range(0, 31);
         3: return ~(32'd1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   function automatic word_type rand_opcode();
      case ($urandom_range(0, 19))
         0: return OP_EXIT;
         1: return 32'd1;
         2: return $urandom;
         3: return $urandom_range(8, 255);
         default: return $urandom_range(OP_MIX, OP_DESC);
      endcase
   endfunction

   function automatic void build_stimulus();
      req_frame_type f;
      word_type      ones;
      ones = ALL_ONES;
      add_row(frm(OP_EXIT, ones, ones, ones, ones, ones, ones, ones), 1'b1,
              '{1'b1, 8'hff, '0});
      add_row(frm(OP_EXIT, 32'h12345600, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6), 1'b1,
              '{1'b1, 8'h00, '0});
      add_row(frm(32'd1, 32'h11111111, 32'h22222222, 32'h33333333, 32'h44444444,
                  32'h55555555, 32'h66666666, 32'h77777777), 1'b1,
              '{1'b0, 8'h00, frm(ALL_ONES, 32'h11111111, 32'h22222222, 32'h33333333,
                                 32'h44444444, 32'h55555555, 32'h66666666, 32'h77777777)});
      add_row(frm(ALL_ONES, ones, ones, ones, ones, ones, ones, ones), 1'b1,
              '{1'b0, 8'h00, frm(ALL_ONES, ones, ones, ones, ones, ones, ones, ones)});
      add_row(frm(32'd8, '0, '0, '0, '0, '0, '0, '0), 1'b1,
              '{1'b0, 8'h00, frm(ALL_ONES, '0, '0, '0, '0, '0, '0, '0)});
      add_row(frm(32'h80000000, 32'hdeadbeef, '0, ones, '0, ones, '0, ones), 1'b1,
              '{1'b0, 8'h00, frm(ALL_ONES, 32'hdeadbeef, '0, ones, '0, ones, '0, ones)});
      add_row(frm(OP_DESC, ones, ones, ones, ones, ones, ones, ones), 1'b1,
              '{1'b0, 8'h00, frm(STATUS_OK, DESC_W1, DESC_W2, DESC_W3, DESC_W4, DESC_W5,
                                 '0, '0)});
      add_row(frm(OP_MAJ, '0, '0, '0, ones, ones, ones, ones), 1'b1,
              '{1'b0, 8'h00, frm(32'd1, '0, '0, '0, ones, ones, ones, ones)});
      add_row(frm(OP_MAJ, ones, ones, ones, '0, '0, '0, '0), 1'b1,
              '{1'b0, 8'h00, frm(STATUS_OK, ones, ones, ones, '0, '0, '0, '0)});
      add_row(frm(OP_ROT, ones, ones, ones, ones, ones, ones, ones), 1'b1,
              '{1'b0, 8'h00, frm(STATUS_OK, ones, ones, ones, ones, ones, ones, ones)});
      add_row(frm(OP_FOLD, ones, ones, ones, ones, ones, ones, ones), 1'b1,
              '{1'b0, 8'h00, frm(STATUS_OK, ones, ones, ones, ones, ones, ones, ones)});
      add_row(frm(OP_FOLD, '0, '0, '0, '0, '0, '0, '0), 1'b1,
              '{1'b0, 8'h00, '0});
      add_row(frm(OP_MIX, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
      add_row(frm(OP_MIX, ones, ones, ones, ones, ones, ones, ones), 1'b0, '0);
      add_row(frm(OP_MIX, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210,
                  32'h0f0f0f0f, 32'hf0f0f0f0, 32'h13579bdf), 1'b0, '0);
      add_row(frm(OP_KEY, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
      add_row(frm(OP_KEY, ones, ones, ones, ones, ones, ones, ones), 1'b0, '0);
      add_row(frm(OP_KEY, KEY_MASK, 32'h1, 32'h2, 32'h4, 32'h8, 32'h10, 32'h20), 1'b0, '0);
      add_row(frm(OP_ROT, 32'h1, 32'h1, 32'h1, 32'h80000000, 32'h80000000, 32'h2, 32'h4),
              1'b0, '0);
      add_row(frm(OP_FOLD, 32'h1, 32'h2, 32'h4, 32'h8, 32'h10, 32'h20, 32'h40), 1'b0, '0);
      add_row(frm(OP_MAJ, 32'hffff0000, 32'h00ffff00, 32'hf0f0f0f0, 32'h1, 32'h2, 32'h3,
                  32'h4), 1'b0, '0);
      add_row(frm(OP_MAJ, '0, '0, 32'h1, '0, '0, '0, '0), 1'b0, '0);
      repeat (RANDOM_ITEMS) begin
         f = frm(rand_opcode(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word(), rand_word());
         if (f[0] == OP_MAJ && $urandom_range(0, 7) == 0) begin
            f[1] = '0;
            f[2] = '0;
            f[3] = '0;
         end
         add_row(f, 1'b0, '0);
      end
   endfunction

   initial begin
      int unsigned  next_idx;
      int unsigned  burst_left;
      int unsigned  gap_left;
      bit           accepted;
      bit           finished;
      stim_row_type row;
      next_idx = 0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
      finished = 1'b0;
      build_stimulus();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (!finished) begin
         @(posedge clock);
         accepted = start && !busy;
         if (accepted) begin
            case (stim_q[next_idx].frame[0])
               OP_EXIT: exit_count++;
               OP_MIX, OP_KEY, OP_ROT, OP_FOLD, OP_MAJ, OP_DESC: xform_count++;
               default: unknown_count++;
            endcase
            next_idx++;
         end
         if (start && !accepted) begin
            // hold the current transfer
         end else if (next_idx == stim_q.size()) begin
            start <= 1'b0;
            finished = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else begin
            row = stim_q[next_idx];
            req_opcode <= row.frame[0];
            req_word1 <= row.frame[1];
            req_word2 <= row.frame[2];
            req_word3 <= row.frame[3];
            req_word4 <= row.frame[4];
            req_word5 <= row.frame[5];
            req_word6 <= row.frame[6];
            req_word7 <= row.frame[7];
            held_expect <= row.typed ? row.result : transform_frame(row.frame);
            start <= 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(0, 3))
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(4, 20);
                  default: gap_left = $urandom_range(1, 5);
               endcase
            end
         end
      end
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d frames: %0d exit requests, %0d transforms, %0d unknown opcodes",
               next_idx, exit_count, xform_count, unknown_count);
      $display("checked %0d results, %0d errors", result_count, err_count);
      if (err_count == 0) begin
         $display("tb_frame_word_mix_unit: clean");
      end else begin
         $display("tb_frame_word_mix_unit: errors");
      end
      $finish;
   end

   always @(posedge clock) begin
      frame_type got;
      frame_type want;
      bit        bad;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_frames.size());
         $display("tb_frame_word_mix_unit: errors");
         $finish;
      end else if (!reset) begin
         if (start && !busy) pending_frames.push_back(held_expect);
         if (rsp_strobe) begin
            got = '{rsp_exit_request, rsp_exit_code,
                    {rsp_out_word7, rsp_out_word6, rsp_out_word5, rsp_out_word4,
                     rsp_out_word3, rsp_out_word2, rsp_out_word1, rsp_status_word}};
            if (pending_frames.size() == 0) begin
               err_count++;
               if (err_count <= REPORT_MAX)
                  $display("result with no transfer pending: %h", got);
            end else begin
               want = pending_frames.pop_front();
               bad = (got.exit_request !== want.exit_request) ||
                     (got.exit_code !== want.exit_code);
               for (int w = 0; w < 8; w++)
                  if (got.words[w] !== want.words[w]) bad = 1'b1;
               if (bad) begin
                  err_count++;
                  if (err_count <= REPORT_MAX) begin
                     $display("mismatch on result %0d", result_count);
                     $display("  expected exit=%b code=%h words=%h", want.exit_request,
                              want.exit_code, want.words);
                     $display("  actual   exit=%b code=%h words=%h", got.exit_request,
                              got.exit_code, got.words);
                  end
               end
            end
            result_count++;
         end
      end
   end

endmodule

// File: filelist.f
rtl/fwm_pkg.sv
rtl/fwm_xform.sv
rtl/fwm_mix_tail.sv
rtl/frame_word_mix_unit.sv
test/tb_frame_word_mix_unit.sv
